>>> design/jpp_pkg.sv
package jpp_pkg;

  // default nesting ceiling and register reset value
  localparam int unsigned MAX_LEVEL_DEF = 63;
  localparam logic [3:0] INDENT_WIDTH_RESET = 4'd2;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned INDENT_W = 10;
  localparam int unsigned WIDTH_W = 4;
  localparam int unsigned OUT_DATA_W = 24;

  // characters with a structural meaning
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  // text scanner flags
  typedef struct packed {
    logic in_quote;
    logic escape_pending;
    logic break_pending;
  } jpp_flags_t;

  // formatting decision for one byte
  typedef struct packed {
    logic newline_before;
    logic [INDENT_W-1:0] indent_spaces;
    logic space_after;
  } jpp_fmt_t;

endpackage

>>> design/jpp_step.sv
module jpp_step import jpp_pkg::*; #(
  parameter int unsigned MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic [$clog2(MAX_LEVEL+1)-1:0] level,
  input  jpp_flags_t                     flags,
  input  logic [BYTE_W-1:0]              prev_byte,
  input  logic [BYTE_W-1:0]              text_byte,
  input  logic                           start_of_text,
  input  logic [WIDTH_W-1:0]             indent_width,
  output logic [$clog2(MAX_LEVEL+1)-1:0] level_next,
  output jpp_flags_t                     flags_next,
  output jpp_fmt_t                       fmt
);

  localparam int unsigned LW = $clog2(MAX_LEVEL+1);
  localparam int unsigned PW = LW + WIDTH_W;
  localparam logic [LW-1:0] LEVEL_MAX = LW'(MAX_LEVEL);

  logic [LW-1:0] cur_level;
  jpp_flags_t cur_flags;
  logic [BYTE_W-1:0] cur_prev;
  logic emit_indent;
  logic [PW-1:0] prod;
  logic [PW+INDENT_W-1:0] prod_ext;

  // start of text clears the state before the byte is handled
  assign cur_level = start_of_text ? '0 : level;
  assign cur_flags = start_of_text ? '0 : flags;
  assign cur_prev = start_of_text ? '0 : prev_byte;

  // per-byte state update and formatting decision
  always_comb begin
    level_next = cur_level;
    flags_next = cur_flags;
    fmt.newline_before = 1'b0;
    fmt.space_after = 1'b0;
    emit_indent = 1'b0;
    case (text_byte)
      CH_BACKSLASH: begin
        if (!cur_flags.escape_pending) begin
          if (cur_flags.in_quote) flags_next.escape_pending = 1'b1;
        end else begin
          flags_next.escape_pending = 1'b0;
        end
      end
      CH_COLON: begin
        if (!cur_flags.in_quote) fmt.space_after = 1'b1;
      end
      CH_QUOTE: begin
        if (cur_flags.break_pending) begin
          fmt.newline_before = 1'b1;
          emit_indent = 1'b1;
          flags_next.break_pending = 1'b0;
        end
        if (!cur_flags.escape_pending) flags_next.in_quote = !cur_flags.in_quote;
        flags_next.escape_pending = 1'b0;
      end
      CH_LBRACE, CH_LBRACKET: begin
        if (!cur_flags.in_quote) begin
          if (cur_level < LEVEL_MAX) level_next = cur_level + LW'(1);
          flags_next.break_pending = 1'b1;
        end else begin
          flags_next.escape_pending = 1'b0;
        end
      end
      CH_RBRACE, CH_RBRACKET: begin
        if (!cur_flags.in_quote) begin
          if (cur_prev != CH_LBRACKET && cur_prev != CH_LBRACE) fmt.newline_before = 1'b1;
          if (cur_level != '0) level_next = cur_level - LW'(1);
          if (!cur_flags.break_pending) emit_indent = 1'b1;
          flags_next.break_pending = 1'b0;
        end else begin
          flags_next.escape_pending = 1'b0;
        end
      end
      CH_COMMA: begin
        if (!cur_flags.in_quote) flags_next.break_pending = 1'b1;
        else flags_next.escape_pending = 1'b0;
      end
      default: begin
        if (text_byte == CH_N || text_byte == CH_B || text_byte == CH_F ||
            text_byte == CH_R || text_byte == CH_T || text_byte == CH_U) begin
          if (cur_flags.in_quote && cur_flags.escape_pending)
            flags_next.escape_pending = 1'b0;
        end
        if (cur_flags.break_pending) begin
          fmt.newline_before = 1'b1;
          emit_indent = 1'b1;
          flags_next.break_pending = 1'b0;
        end
      end
    endcase

    // indent from the level after this byte, kept to ten bits
    prod = PW'(level_next) * PW'(indent_width);
    prod_ext = {{INDENT_W{1'b0}}, prod};
    fmt.indent_spaces = emit_indent ? prod_ext[INDENT_W-1:0] : '0;
  end

endmodule

>>> design/json_text_pretty_printer.sv
// channel   | direction | payload
// s_axis    | in        | tdata: text_byte[7:0]; tuser: start_of_text
// m_axis    | out       | tdata: newline_before, indent_spaces, out_byte, space_after
// cfg_wr    | in        | indent_width[3:0], written when cfg_wr_en is high
//
// one byte per cycle sustained while the output is not stalled; the scanner
// state (level, flags, previous byte) closes its loop through the step logic
// bytes pass through the input register, then the result register
// rst is synchronous and clears the scanner state, indent_width returns to 2
// a stalled result holds while the input register still takes one byte
module json_text_pretty_printer import jpp_pkg::*; #(
  parameter int unsigned MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,  // text_byte[7:0]
  input  logic                  s_axis_tuser,  // start_of_text
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // newline_before[0], indent_spaces[10:1], out_byte[18:11], space_after[19], zeros
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [WIDTH_W-1:0]    cfg_wr_data
);

  localparam int unsigned LW = $clog2(MAX_LEVEL+1);
  localparam int unsigned PAD_W = OUT_DATA_W - (2 + INDENT_W + BYTE_W);

  logic [WIDTH_W-1:0] indent_width;
  logic in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic in_start;
  logic advance;
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  jpp_flags_t flags;
  jpp_flags_t flags_next;
  logic [BYTE_W-1:0] prev_byte;
  jpp_fmt_t fmt;
  jpp_fmt_t out_fmt;
  logic [BYTE_W-1:0] out_byte;

  // result register moves when empty or taken
  assign advance = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) indent_width <= INDENT_WIDTH_RESET;
    else if (cfg_wr_en) indent_width <= cfg_wr_data;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  jpp_step #(
    .MAX_LEVEL(MAX_LEVEL)
  ) u_step (
    .level        (level),
    .flags        (flags),
    .prev_byte    (prev_byte),
    .text_byte    (in_byte),
    .start_of_text(in_start),
    .indent_width (indent_width),
    .level_next   (level_next),
    .flags_next   (flags_next),
    .fmt          (fmt)
  );

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      flags <= '0;
      prev_byte <= '0;
    end else if (advance) begin
      level <= level_next;
      flags <= flags_next;
      prev_byte <= in_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fmt <= fmt;
      out_byte <= in_byte;
    end
  end

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_fmt.space_after, out_byte,
                         out_fmt.indent_spaces, out_fmt.newline_before};

`ifndef ASSERT_OFF
  // level stays within its ceiling
  assert property (@(posedge clk) disable iff (rst) level <= LW'(MAX_LEVEL))
    else $error("nest level above ceiling");

  // a colon space and a line break never come together
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_fmt.newline_before && out_fmt.space_after))
    else $error("newline and space on the same byte");

  // space after only for a colon
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_fmt.space_after) |-> (out_byte == CH_COLON))
    else $error("space after a byte other than colon");

  // a held input byte is not lost while the result stalls
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_byte)))
    else $error("input register dropped a stalled byte");
`endif

endmodule

>>> tb/sv/json_text_pretty_printer_tb.sv
module json_text_pretty_printer_tb;
  import jpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PER_PHASE = 170;

  // one byte of text as offered on the input stream
  typedef struct {
    logic [7:0] text_byte;
    logic       start;
  } text_item_t;

  // formatting of one byte as it leaves the block
  typedef struct packed {
    logic                newline_before;
    logic [INDENT_W-1:0] indent_spaces;
    logic [7:0]          out_byte;
    logic                space_after;
  } fmt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [BYTE_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_wr_en = 1'b0;
  logic [WIDTH_W-1:0] cfg_wr_data = '0;

  // text bytes waiting to be sent and formatting still to come back
  text_item_t text_q[$];
  fmt_result_t fmt_q[$];

  // scanner state mirrored from the block
  int unsigned nest_lvl;
  logic in_quote_m;
  logic escape_m;
  logic break_m;
  logic [7:0] prev_byte_m;
  logic [WIDTH_W-1:0] indent_w_m;

  logic src_idle_en = 1'b0;
  logic sink_idle_en = 1'b0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  int unsigned accepted_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;

  json_text_pretty_printer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // indent for the current level
  function automatic logic [INDENT_W-1:0] level_indent();
    int unsigned prod;
    prod = nest_lvl * indent_w_m;
    return prod[INDENT_W-1:0];
  endfunction

  // formatting decision for one byte, advancing the mirrored scanner state
  function automatic fmt_result_t format_byte(logic [7:0] c, logic sot);
    fmt_result_t r;
    r = '0;
    r.out_byte = c;
    if (sot) begin
      nest_lvl = 0;
      in_quote_m = 1'b0;
      escape_m = 1'b0;
      break_m = 1'b0;
      prev_byte_m = '0;
    end
    case (c)
      CH_BACKSLASH: begin
        if (!escape_m) begin
          if (in_quote_m) escape_m = 1'b1;
        end else begin
          escape_m = 1'b0;
        end
      end
      CH_COLON: begin
        if (!in_quote_m) r.space_after = 1'b1;
      end
      CH_QUOTE: begin
        if (break_m) begin
          r.newline_before = 1'b1;
          r.indent_spaces = level_indent();
          break_m = 1'b0;
        end
        if (!escape_m) in_quote_m = !in_quote_m;
        escape_m = 1'b0;
      end
      CH_LBRACE, CH_LBRACKET: begin
        if (!in_quote_m) begin
          if (nest_lvl < MAX_LEVEL_DEF) nest_lvl++;
          break_m = 1'b1;
        end else begin
          escape_m = 1'b0;
        end
      end
      CH_RBRACE, CH_RBRACKET: begin
        if (!in_quote_m) begin
          if (prev_byte_m != CH_LBRACKET && prev_byte_m != CH_LBRACE) r.newline_before = 1'b1;
          if (nest_lvl > 0) nest_lvl--;
          if (!break_m) r.indent_spaces = level_indent();
          break_m = 1'b0;
        end else begin
          escape_m = 1'b0;
        end
      end
      CH_COMMA: begin
        if (!in_quote_m) break_m = 1'b1;
        else escape_m = 1'b0;
      end
      default: begin
        // only the escape letters end an escape here
        if (c inside {CH_N, CH_B, CH_F, CH_R, CH_T, CH_U}) begin
          if (in_quote_m && escape_m) escape_m = 1'b0;
        end
        if (break_m) begin
          r.newline_before = 1'b1;
          r.indent_spaces = level_indent();
          break_m = 1'b0;
        end
      end
    endcase
    prev_byte_m = c;
    return r;
  endfunction

  // input driver and prediction of each accepted transaction
  always @(posedge clk) begin
    text_item_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      nest_lvl = 0;
      in_quote_m = 1'b0;
      escape_m = 1'b0;
      break_m = 1'b0;
      prev_byte_m = '0;
      indent_w_m = INDENT_WIDTH_RESET;
    end else begin
      if (cfg_wr_en) indent_w_m = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        fmt_q.insert(fmt_q.size(), format_byte(s_axis_tdata, s_axis_tuser));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (src_idle_en && $urandom_range(0, 4) == 0) begin
          src_gap <= $urandom_range(0, 3);
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() != 0) begin
          item = text_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= item.text_byte;
          s_axis_tuser <= item.start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (sink_gap != 0) begin
      m_axis_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    fmt_result_t want;
    fmt_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.newline_before = m_axis_tdata[0];
      got.indent_spaces = m_axis_tdata[10:1];
      got.out_byte = m_axis_tdata[18:11];
      got.space_after = m_axis_tdata[19];
      if (fmt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: tdata=%h", m_axis_tdata);
      end else begin
        want = fmt_q.pop_front();
        if (got.newline_before != want.newline_before ||
            got.indent_spaces != want.indent_spaces ||
            got.out_byte != want.out_byte ||
            got.space_after != want.space_after) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch byte %h: expected nl=%0d ind=%0d sp=%0d, ",
                      "got byte %h nl=%0d ind=%0d sp=%0d"},
                     want.out_byte, want.newline_before, want.indent_spaces, want.space_after,
                     got.out_byte, got.newline_before, got.indent_spaces, got.space_after);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("json_text_pretty_printer_tb: FAIL");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic sot);
    text_item_t item;
    item.text_byte = b;
    item.start = sot;
    text_q.insert(text_q.size(), item);
  endtask

  // wait until everything sent has come back, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (text_q.size() != 0 || s_axis_tvalid || fmt_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_indent(input logic [WIDTH_W-1:0] w);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // nest past the level ceiling, then close past level zero
  task automatic add_deep_text();
    int unsigned depth;
    depth = $urandom_range(64, 68);
    add_byte(CH_LBRACE, 1'b1);
    for (int i = 1; i < depth; i++)
      add_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET, 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte("a", 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    for (int i = 0; i < depth + 2; i++)
      add_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET, 1'b0);
  endtask

  // a quoted string with escapes and structural characters inside
  task automatic add_string(inout int unsigned n);
    int unsigned len;
    logic [7:0] esc_chars [11];
    esc_chars = '{CH_QUOTE, CH_BACKSLASH, CH_N, CH_B, CH_F, CH_R, CH_T, CH_U, "/", "x", "{"};
    len = $urandom_range(0, 6);
    add_byte(CH_QUOTE, 1'b0);
    n++;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        add_byte(CH_BACKSLASH, 1'b0);
        add_byte($urandom_range(0, 5) == 0 ? 8'($urandom_range(0, 255))
                                             : esc_chars[$urandom_range(0, 10)], 1'b0);
        n += 2;
      end else begin
        case ($urandom_range(0, 5))
          0: add_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET, 1'b0);
          1: add_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET, 1'b0);
          2: add_byte($urandom_range(0, 1) ? CH_COMMA : CH_COLON, 1'b0);
          default: add_byte(8'($urandom_range(32, 126)), 1'b0);
        endcase
        n++;
      end
    end
    add_byte(CH_QUOTE, 1'b0);
    n++;
  endtask

  // mostly well-formed json-like text with some noise
  task automatic add_random_text(input int unsigned count);
    int unsigned n;
    int unsigned r;
    logic [7:0] word_chars [14];
    word_chars = '{CH_N, CH_B, CH_F, CH_R, CH_T, CH_U, "a", "e", "l", "s", "0", "7", "-", " "};
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_byte(CH_LBRACE, 1'b0);
        n++;
      end else if (r < 20) begin
        add_byte(CH_LBRACKET, 1'b0);
        n++;
      end else if (r < 32) begin
        add_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET, 1'b0);
        n++;
      end else if (r < 44) begin
        add_byte(CH_COMMA, 1'b0);
        n++;
      end else if (r < 52) begin
        add_byte(CH_COLON, 1'b0);
        n++;
      end else if (r < 70) begin
        add_string(n);
      end else if (r < 82) begin
        add_byte(word_chars[$urandom_range(0, 13)], 1'b0);
        n++;
      end else if (r < 94) begin
        add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        add_byte($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACKET, 1'b1);
        n++;
      end
    end
  endtask

  // stimulus
  initial begin
    logic [WIDTH_W-1:0] phase_width [5];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed text at the reset indent width
    add_byte(CH_RBRACE, 1'b1);
    add_byte(CH_RBRACKET, 1'b0);
    add_byte(CH_LBRACE, 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte("k", 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(CH_LBRACKET, 1'b0);
    add_byte(CH_RBRACKET, 1'b0);
    add_byte(CH_COMMA, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(CH_BACKSLASH, 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte(CH_BACKSLASH, 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte(CH_BACKSLASH, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(CH_U, 1'b0);
    add_byte(CH_LBRACE, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(CH_QUOTE, 1'b0);
    add_byte(CH_RBRACE, 1'b0);
    add_byte(CH_LBRACKET, 1'b0);
    add_byte(CH_RBRACKET, 1'b1);
    drain();

    // phases at several indent widths, extremes included
    phase_width = '{4'd15, 4'd0, 4'd1, 4'($urandom_range(2, 14)), 4'd15};
    for (int p = 0; p < 5; p++) begin
      write_indent(phase_width[p]);
      @(posedge clk);
      src_idle_en <= (p == 0 || p == 1 || p == 2);
      sink_idle_en <= (p == 0 || p == 1 || p == 3);
      add_deep_text();
      add_random_text(RANDOM_PER_PHASE);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && fmt_q.size() == 0) begin
      $display("json_text_pretty_printer_tb: PASS");
    end else begin
      $display("json_text_pretty_printer_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/jpp_pkg.sv
design/jpp_step.sv
design/json_text_pretty_printer.sv
tb/sv/json_text_pretty_printer_tb.sv
